// ===== sv/tkst_pkg.sv =====
// Shared types, constants and control structures of the top-K sorted insert table.
`default_nettype none
package tkst_pkg;

	// Default table depth and the fixed field widths of the channels.
	localparam int DEPTH_K_DEF = 8;
	localparam int ScoreW      = 16;
	localparam int TagW        = 24;
	localparam int ByteW       = 8;
	localparam int SlotW       = 3;
	localparam int RankW       = 3;
	localparam int CountW      = 4;
	// Widest internal index or count, for a depth of up to 64.
	localparam int WideW       = 7;
	// Slots that read_slot can address.
	localparam int ReadSlots   = 1 << SlotW;

	// Tag of an empty entry: three dash characters.
	localparam logic [TagW-1:0] DASH_TAG = 24'h2D2D2D;

	// Action codes carried by an input beat.
	typedef enum logic [1:0] {
		ACT_RANK   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// One table entry.
	typedef struct packed {
		logic [ScoreW-1:0] score;
		logic [TagW-1:0]   tag;
		logic [ByteW-1:0]  level;
		logic [ByteW-1:0]  flags;
	} entry_t;

	localparam entry_t EMPTY_ENTRY = '{score: '0, tag: DASH_TAG, level: '0, flags: '0};

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic   insert;
		logic   clear;
		entry_t ins;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== sv/tkst_if.sv =====
// Handshake interfaces of the input and result channels.
`default_nettype none
interface tkst_in_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic [tkst_pkg::ScoreW-1:0] score;
	logic [tkst_pkg::TagW-1:0]   tag;
	logic [tkst_pkg::ByteW-1:0]  level_reached;
	logic [tkst_pkg::ByteW-1:0]  entry_flags;
	logic [tkst_pkg::SlotW-1:0]  read_slot;

	modport source (output valid, action, score, tag, level_reached, entry_flags, read_slot,
		input ready);
	modport sink (input valid, action, score, tag, level_reached, entry_flags, read_slot,
		output ready);
endinterface

interface tkst_out_if;
	logic                        valid;
	logic                        ready;
	logic                        qualifies;
	logic [tkst_pkg::RankW-1:0]  rank;
	logic [tkst_pkg::CountW-1:0] fill_count;
	logic [tkst_pkg::ScoreW-1:0] out_score;
	logic [tkst_pkg::TagW-1:0]   out_tag;
	logic [tkst_pkg::ByteW-1:0]  out_level;
	logic [tkst_pkg::ByteW-1:0]  out_flags;

	modport source (output valid, qualifies, rank, fill_count, out_score, out_tag, out_level,
		out_flags, input ready);
	modport sink (input valid, qualifies, rank, fill_count, out_score, out_tag, out_level,
		out_flags, output ready);
endinterface
`default_nettype wire

// ===== sv/tkst_cell.sv =====
// One slot of the sorted table: compares the incoming score and shifts or loads on insert.
`default_nettype none
module tkst_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tkst_pkg::ctrl_t ctrl,
	input  wire tkst_pkg::entry_t prev_entry,
	input  wire logic            prev_gt,
	output tkst_pkg::entry_t     entry,
	output logic                 gt
);

	tkst_pkg::entry_t entry_q;

	// The new score beats this slot. Empty slots hold score zero, so any
	// non-zero score beats them, and a zero score beats nothing.
	assign gt    = ctrl.ins.score > entry_q.score;
	assign entry = entry_q;

	// A slot beaten by the new score takes its upper neighbour's entry when
	// that one is beaten too, and the new entry when it is the first beaten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= tkst_pkg::EMPTY_ENTRY;
		end else if (ctrl.clear) begin
			entry_q <= tkst_pkg::EMPTY_ENTRY;
		end else if (ctrl.insert && gt) begin
			entry_q <= prev_gt ? prev_entry : ctrl.ins;
		end
	end

endmodule
`default_nettype wire

// ===== sv/top_k_sorted_insert_table.sv =====
// Top level of the top-K sorted insert table: cell row, fill count and result register.
//
//   channel   direction   handshake     carries
//   in_ch     sink        valid/ready   action, score, tag, level_reached, entry_flags, read_slot
//   out_ch    source      valid/ready   qualifies, rank, fill_count, out_score/tag/level/flags
//
// Every beat is ranked against all cells in the cycle it is accepted; one beat per cycle
// while the result is not stalled. The result appears in the output register on the following
// cycle. A new beat is taken while the held result is being taken, so only a stalled result
// holds back the input. Reset fills every slot with the empty entry and zeroes the count.
`default_nettype none
module top_k_sorted_insert_table #(
	parameter int DEPTH_K = tkst_pkg::DEPTH_K_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tkst_in_if.sink   in_ch,
	tkst_out_if.source out_ch
);

	localparam int IdxW  = $clog2(DEPTH_K);
	localparam int FillW = $clog2(DEPTH_K + 1);
	localparam int ReadN = (DEPTH_K < tkst_pkg::ReadSlots) ? DEPTH_K : tkst_pkg::ReadSlots;

	tkst_pkg::action_t act;
	tkst_pkg::ctrl_t   ctrl;
	tkst_pkg::entry_t  cell_entry [DEPTH_K];
	tkst_pkg::entry_t  rd_entry;
	logic [DEPTH_K-1:0] gt;
	logic [DEPTH_K-1:0] first;
	logic [IdxW-1:0]   rank_idx;
	logic              qual;
	logic              accept;
	logic [FillW-1:0]  fill_q;
	logic [FillW-1:0]  fill_next;
	logic              out_valid_q;

	assign act    = tkst_pkg::action_t'(in_ch.action);
	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !out_valid_q || out_ch.ready;

	// Broadcast to the cells.
	always_comb begin
		ctrl.insert    = accept && (act == tkst_pkg::ACT_INSERT);
		ctrl.clear     = accept && (act == tkst_pkg::ACT_CLEAR);
		ctrl.ins.score = in_ch.score;
		ctrl.ins.tag   = in_ch.tag;
		ctrl.ins.level = in_ch.level_reached;
		ctrl.ins.flags = in_ch.entry_flags;
	end

	// The row of cells; each hands its entry and compare result to the next.
	for (genvar i = 0; i < DEPTH_K; i++) begin : g_cell
		if (i == 0) begin : g_head
			tkst_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_entry (ctrl.ins),
				.prev_gt    (1'b0),
				.entry      (cell_entry[i]),
				.gt         (gt[i])
			);
		end else begin : g_body
			tkst_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_entry (cell_entry[i-1]),
				.prev_gt    (gt[i-1]),
				.entry      (cell_entry[i]),
				.gt         (gt[i])
			);
		end
	end

	// The table is sorted, so the beaten slots form a tail of the row. The
	// rank is the first beaten slot, and the last slot is beaten whenever any is.
	assign first = gt & ~{gt[DEPTH_K-2:0], 1'b0};
	assign qual  = gt[DEPTH_K-1];

	always_comb begin
		rank_idx = '0;
		for (int i = 0; i < DEPTH_K; i++) begin
			if (first[i]) begin
				rank_idx = rank_idx | IdxW'(i);
			end
		end
	end

	// Read port over the slots that read_slot can reach.
	always_comb begin
		rd_entry = tkst_pkg::EMPTY_ENTRY;
		for (int i = 0; i < ReadN; i++) begin
			if (in_ch.read_slot == tkst_pkg::SlotW'(i)) begin
				rd_entry = cell_entry[i];
			end
		end
	end

	// Fill count after this beat.
	always_comb begin
		fill_next = fill_q;
		case (act)
			tkst_pkg::ACT_CLEAR: begin
				fill_next = '0;
			end
			tkst_pkg::ACT_INSERT: begin
				if (qual && (fill_q != FillW'(DEPTH_K))) begin
					fill_next = fill_q + FillW'(1);
				end
			end
			default: begin
				fill_next = fill_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
		end
	end

	// Result register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [tkst_pkg::WideW-1:0] rank_wide;
	logic [tkst_pkg::WideW-1:0] fill_wide;
	assign rank_wide = tkst_pkg::WideW'(rank_idx);
	assign fill_wide = tkst_pkg::WideW'(fill_next);

	logic                           qual_q;
	logic [tkst_pkg::RankW-1:0]     rank_q;
	logic [tkst_pkg::CountW-1:0]    fill_out_q;
	tkst_pkg::entry_t               rd_q;
	logic                           ranked;

	// Rank and qualifies only for query and insert; entry fields only for read.
	assign ranked = (act == tkst_pkg::ACT_RANK) || (act == tkst_pkg::ACT_INSERT);

	always_ff @(posedge clk) begin
		if (accept) begin
			qual_q     <= ranked && qual;
			rank_q     <= (ranked && qual) ? rank_wide[tkst_pkg::RankW-1:0] : '0;
			fill_out_q <= fill_wide[tkst_pkg::CountW-1:0];
			rd_q       <= (act == tkst_pkg::ACT_READ) ? rd_entry : '0;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.qualifies  = qual_q;
	assign out_ch.rank       = rank_q;
	assign out_ch.fill_count = fill_out_q;
	assign out_ch.out_score  = rd_q.score;
	assign out_ch.out_tag    = rd_q.tag;
	assign out_ch.out_level  = rd_q.level;
	assign out_ch.out_flags  = rd_q.flags;

endmodule
`default_nettype wire

// ===== sim/top_k_sorted_insert_table_tb.sv =====
// Self-checking testbench of the top-K sorted insert table: directed rows, then random beats.
module top_k_sorted_insert_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tkst_pkg::*;

	localparam int TABLE_DEPTH  = DEPTH_K_DEF;
	localparam int RANDOM_BEATS = 1350;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_LIMIT = 10;
	localparam int CYCLE_LIMIT  = 200000;

	// One input beat as the predictor sees it.
	typedef struct packed {
		action_t           action;
		logic [ScoreW-1:0] score;
		logic [TagW-1:0]   tag;
		logic [ByteW-1:0]  level;
		logic [ByteW-1:0]  flags;
		logic [SlotW-1:0]  read_slot;
	} candidate_t;

	// One result beat, in port order.
	typedef struct packed {
		logic              qualifies;
		logic [RankW-1:0]  rank;
		logic [CountW-1:0] fill_count;
		logic [ScoreW-1:0] score;
		logic [TagW-1:0]   tag;
		logic [ByteW-1:0]  level;
		logic [ByteW-1:0]  flags;
	} table_result_t;

	// A stimulus row: the beat, and a hand-written answer where one is given.
	typedef struct packed {
		candidate_t    beat;
		logic          typed;
		table_result_t want;
	} plan_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	tkst_in_if  in_ch ();
	tkst_out_if out_ch ();

	top_k_sorted_insert_table #(
		.DEPTH_K(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Predicted copy of the table.
	entry_t ranked_entry [TABLE_DEPTH];
	int     ranked_count;

	table_result_t expected_results [$];
	plan_row_t     offered_rows [$];

	int send_idle_pct = 31;
	int recv_idle_pct = 73;
	int phase         = 0;
	int failures      = 0;
	int cycle_count   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_ranking();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ranked_entry[i] = EMPTY_ENTRY;
		end
		ranked_count = 0;
	endfunction

	// Ranks a beat against the predicted table, applies it, and returns the expected result.
	function automatic table_result_t rank_and_update(candidate_t c);
		table_result_t r;
		entry_t        e;
		int            pos;
		bit            hit;
		r   = '0;
		pos = 0;
		hit = 1'b0;
		// The first filled slot strictly below the score; else the next free slot.
		if (c.score != '0) begin
			for (int i = 0; i < ranked_count; i++) begin
				if (!hit && c.score > ranked_entry[i].score) begin
					pos = i;
					hit = 1'b1;
				end
			end
			if (!hit && ranked_count < TABLE_DEPTH) begin
				pos = ranked_count;
				hit = 1'b1;
			end
		end
		case (c.action)
			ACT_RANK: begin
				if (hit) begin
					r.qualifies = 1'b1;
					r.rank      = pos[RankW-1:0];
				end
			end
			ACT_INSERT: begin
				if (hit) begin
					for (int i = TABLE_DEPTH - 1; i > pos; i--) begin
						ranked_entry[i] = ranked_entry[i-1];
					end
					e.score = c.score;
					e.tag   = c.tag;
					e.level = c.level;
					e.flags = c.flags;
					ranked_entry[pos] = e;
					if (ranked_count < TABLE_DEPTH) begin
						ranked_count++;
					end
					r.qualifies = 1'b1;
					r.rank      = pos[RankW-1:0];
				end
			end
			ACT_READ: begin
				if (c.read_slot < TABLE_DEPTH) begin
					e       = ranked_entry[c.read_slot];
					r.score = e.score;
					r.tag   = e.tag;
					r.level = e.level;
					r.flags = e.flags;
				end else begin
					r.tag = DASH_TAG;
				end
			end
			default: begin
				clear_ranking();
			end
		endcase
		r.fill_count = ranked_count[CountW-1:0];
		return r;
	endfunction

	function automatic plan_row_t beat_row(action_t a, logic [ScoreW-1:0] s, logic [TagW-1:0] t,
			logic [ByteW-1:0] l, logic [ByteW-1:0] f, logic [SlotW-1:0] rs);
		plan_row_t p;
		p                = '0;
		p.beat.action    = a;
		p.beat.score     = s;
		p.beat.tag       = t;
		p.beat.level     = l;
		p.beat.flags     = f;
		p.beat.read_slot = rs;
		return p;
	endfunction

	function automatic plan_row_t with_answer(plan_row_t p, logic q, logic [RankW-1:0] rk,
			logic [CountW-1:0] fc, logic [ScoreW-1:0] s, logic [TagW-1:0] t,
			logic [ByteW-1:0] l, logic [ByteW-1:0] f);
		p.typed           = 1'b1;
		p.want.qualifies  = q;
		p.want.rank       = rk;
		p.want.fill_count = fc;
		p.want.score      = s;
		p.want.tag        = t;
		p.want.level      = l;
		p.want.flags      = f;
		return p;
	endfunction

	// Random beat: mostly inserts and reads, scores biased towards zero, extremes and ties.
	function automatic plan_row_t random_row();
		plan_row_t p;
		int        roll;
		int        pick;
		p    = '0;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		if (roll < 30) begin
			p.beat.action = ACT_RANK;
		end else if (roll < 72) begin
			p.beat.action = ACT_INSERT;
		end else if (roll < 96) begin
			p.beat.action = ACT_READ;
		end else begin
			p.beat.action = ACT_CLEAR;
		end
		case (pick)
			0: p.beat.score = '0;
			1: p.beat.score = '1;
			2, 3, 4, 5: p.beat.score = ScoreW'($urandom_range(1, 24));
			default: p.beat.score = ScoreW'($urandom);
		endcase
		p.beat.tag       = TagW'($urandom);
		p.beat.level     = ByteW'($urandom);
		p.beat.flags     = ByteW'($urandom);
		p.beat.read_slot = SlotW'($urandom);
		return p;
	endfunction

	function automatic string show(table_result_t r);
		return $sformatf("q=%0d rank=%0d fill=%0d score=%h tag=%h level=%h flags=%h",
			r.qualifies, r.rank, r.fill_count, r.score, r.tag, r.level, r.flags);
	endfunction

	// Offers one beat, idling the input first at random, and returns once it is taken.
	task automatic offer_beat(plan_row_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.action        <= p.beat.action;
		in_ch.score         <= p.beat.score;
		in_ch.tag           <= p.beat.tag;
		in_ch.level_reached <= p.beat.level;
		in_ch.entry_flags   <= p.beat.flags;
		in_ch.read_slot     <= p.beat.read_slot;
		offered_rows.push_back(p);
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Stimulus: reset, the directed table, then three random phases of idling.
	initial begin
		plan_row_t plan [$];
		in_ch.valid         <= 1'b0;
		in_ch.action        <= ACT_RANK;
		in_ch.score         <= '0;
		in_ch.tag           <= '0;
		in_ch.level_reached <= '0;
		in_ch.entry_flags   <= '0;
		in_ch.read_slot     <= '0;
		clear_ranking();

		// Empty table, zero scores, ties, a full table and clearing.
		plan.push_back(with_answer(beat_row(ACT_READ, 16'd0, 24'h0, 8'h0, 8'h0, 3'd0),
			1'b0, 3'd0, 4'd0, 16'd0, DASH_TAG, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_RANK, 16'd0, 24'h0, 8'h0, 8'h0, 3'd0),
			1'b0, 3'd0, 4'd0, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_RANK, 16'd1, 24'h0, 8'h0, 8'h0, 3'd0),
			1'b1, 3'd0, 4'd0, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_INSERT, 16'd0, 24'h414141, 8'h11, 8'h22, 3'd0),
			1'b0, 3'd0, 4'd0, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_INSERT, 16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 3'd7),
			1'b1, 3'd0, 4'd1, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_INSERT, 16'd1, 24'h000000, 8'h00, 8'h00, 3'd0),
			1'b1, 3'd1, 4'd2, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_INSERT, 16'hFFFF, 24'h414243, 8'h01, 8'h80, 3'd0),
			1'b1, 3'd1, 4'd3, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(beat_row(ACT_INSERT, 16'd500, 24'h444444, 8'h05, 8'h01, 3'd0));
		plan.push_back(beat_row(ACT_INSERT, 16'd100, 24'h454545, 8'h01, 8'h02, 3'd0));
		plan.push_back(beat_row(ACT_INSERT, 16'd300, 24'h464646, 8'h03, 8'h04, 3'd0));
		plan.push_back(beat_row(ACT_INSERT, 16'd200, 24'h474747, 8'h02, 8'h08, 3'd0));
		plan.push_back(beat_row(ACT_INSERT, 16'd400, 24'h484848, 8'h04, 8'h10, 3'd0));
		plan.push_back(with_answer(beat_row(ACT_INSERT, 16'd1, 24'h494949, 8'h09, 8'h09, 3'd0),
			1'b0, 3'd0, 4'd8, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_RANK, 16'd1, 24'h0, 8'h0, 8'h0, 3'd0),
			1'b0, 3'd0, 4'd8, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(beat_row(ACT_RANK, 16'hFFFF, 24'h0, 8'h0, 8'h0, 3'd0));
		plan.push_back(beat_row(ACT_INSERT, 16'd2, 24'h5A5A5A, 8'hAA, 8'h55, 3'd0));
		plan.push_back(beat_row(ACT_READ, 16'd0, 24'h0, 8'h0, 8'h0, 3'd7));
		plan.push_back(with_answer(beat_row(ACT_READ, 16'd0, 24'h0, 8'h0, 8'h0, 3'd0),
			1'b0, 3'd0, 4'd8, 16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF));
		plan.push_back(beat_row(ACT_READ, 16'd0, 24'h0, 8'h0, 8'h0, 3'd1));
		plan.push_back(with_answer(beat_row(ACT_CLEAR, 16'hFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 3'd7),
			1'b0, 3'd0, 4'd0, 16'd0, 24'h0, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_READ, 16'd0, 24'h0, 8'h0, 8'h0, 3'd3),
			1'b0, 3'd0, 4'd0, 16'd0, DASH_TAG, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_READ, 16'd0, 24'h0, 8'h0, 8'h0, 3'd7),
			1'b0, 3'd0, 4'd0, 16'd0, DASH_TAG, 8'h0, 8'h0));
		plan.push_back(with_answer(beat_row(ACT_INSERT, 16'h8000, 24'h4A4B4C, 8'h7F, 8'h01, 3'd0),
			1'b1, 3'd0, 4'd1, 16'd0, 24'h0, 8'h0, 8'h0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			offer_beat(plan[i]);
		end

		// Sender mostly active, receiver mostly stalling; then the reverse; then no idling and one long stall.
		for (int seg = 0; seg < 3; seg++) begin
			phase         = seg;
			send_idle_pct = (seg == 0) ? 31 : (seg == 1) ? 73 : 0;
			recv_idle_pct = (seg == 0) ? 73 : (seg == 1) ? 31 : 0;
			repeat (RANDOM_BEATS / 3) begin
				offer_beat(random_row());
			end
		end
		in_ch.valid <= 1'b0;

		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Result side: random back-pressure, and one long hold at the start of the last phase.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (phase == 2 && !held) begin
				hold_left = HOLD_CYCLES;
				held      = 1'b1;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Checks each result beat against the oldest expectation, then predicts each taken input beat.
	always @(posedge clk) begin : result_check
		table_result_t got;
		table_result_t want;
		candidate_t    c;
		plan_row_t     p;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.qualifies  = out_ch.qualifies;
				got.rank       = out_ch.rank;
				got.fill_count = out_ch.fill_count;
				got.score      = out_ch.out_score;
				got.tag        = out_ch.out_tag;
				got.level      = out_ch.out_level;
				got.flags      = out_ch.out_flags;
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("%0t: result beat with nothing expected: %s", $realtime, show(got));
					end
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= REPORT_LIMIT) begin
							$display("%0t: mismatch: expected %s", $realtime, show(want));
							$display("%0t:           got      %s", $realtime, show(got));
						end
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				c.action    = action_t'(in_ch.action);
				c.score     = in_ch.score;
				c.tag       = in_ch.tag;
				c.level     = in_ch.level_reached;
				c.flags     = in_ch.entry_flags;
				c.read_slot = in_ch.read_slot;
				want        = rank_and_update(c);
				p           = offered_rows.pop_front();
				// Hand-written answers take the place of the prediction.
				if (p.typed) begin
					want = p.want;
				end
				expected_results.push_back(want);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

endmodule
